// ===== src/dual_absolute_encoder_odometry_top_macros.svh =====
// assertion macros for the wheel odometry block
`ifndef DUAL_ABSOLUTE_ENCODER_ODOMETRY_TOP_MACROS_SVH
`define DUAL_ABSOLUTE_ENCODER_ODOMETRY_TOP_MACROS_SVH

// checked property, switched off while reset is high
`define DEO_ASSERT_RUN(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property that also holds across reset
`define DEO_ASSERT_ALL(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/deo_pkg.sv =====
// shared types and constants of the wheel odometry block
package deo_pkg;

   // fixed field widths
   localparam int THR_W    = 12;
   localparam int REG_W    = 32;
   localparam int DT_W     = 32;
   localparam int OUT_W    = 32;
   localparam int DIST_W   = 33;
   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_PER_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_TRACK_WIDTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_THRESHOLD  = 2'd2;

   // register reset values
   localparam logic [REG_W-1:0] DPC_RESET = 32'd128680;
   localparam logic [REG_W-1:0] INV_RESET = 32'd16777216;
   localparam logic [THR_W-1:0] THR_RESET = 12'd2608;

   // arithmetic constants
   localparam int VEL_SCALE   = 1000;
   localparam int DIST_SHIFT  = 8;
   localparam int TURN_SHIFT  = 24;
   localparam int DIV_N       = 42;
   localparam int VEL_W       = 43;
   localparam int SUM_W       = 44;
   localparam int MUL_DIGIT   = 8;
   localparam int MUL_STEPS   = 4;
   localparam int CNT_W       = 6;

   // multiplier operand select
   localparam logic [1:0] MSEL_LEFT  = 2'd0;
   localparam logic [1:0] MSEL_RIGHT = 2'd1;
   localparam logic [1:0] MSEL_DIFF  = 2'd2;

   // commands from controller to datapath
   typedef struct packed {
      logic       load;
      logic       cal;
      logic       ang;
      logic       mul_start;
      logic [1:0] mul_sel;
      logic       mul_step;
      logic       dist_l;
      logic       dist_r;
      logic       scale;
      logic       div_start;
      logic       div_step;
      logic       vel;
      logic       mix;
      logic       out_load;
   } deo_cmd_type;

endpackage

// ===== src/deo_div.sv =====
// restoring radix-2 divider, one quotient bit per step
module deo_div #(
   parameter int N = 42,
   parameter int D = 32
) (
   input  logic         clock,
   input  logic         start,
   input  logic         step,
   input  logic [N-1:0] dividend,
   input  logic [D-1:0] divisor,
   output logic [N-1:0] quotient
);

   logic [D-1:0] rem_ff, rem_in;
   logic [N-1:0] q_ff, q_in;
   logic [D:0]   rem_sh;
   logic [D:0]   trial;
   logic         ge;

   // trial subtract of shifted remainder
   always_comb begin
      rem_sh = {rem_ff, q_ff[N-1]};
      trial  = rem_sh - {1'b0, divisor};
      ge     = ~trial[D];
      rem_in = rem_ff;
      q_in   = q_ff;
      if (start) begin
         rem_in = '0;
         q_in   = dividend;
      end else if (step) begin
         rem_in = ge ? trial[D-1:0] : rem_sh[D-1:0];
         q_in   = {q_ff[N-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign quotient = q_ff;

endmodule

// ===== src/deo_ctrl.sv =====
// sequencing state machine of the wheel odometry block
module deo_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_action,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output deo_pkg::deo_cmd_type cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ANG   = 4'd1;
   localparam logic [3:0] S_MLS   = 4'd2;
   localparam logic [3:0] S_MULL  = 4'd3;
   localparam logic [3:0] S_DSTL  = 4'd4;
   localparam logic [3:0] S_MULR  = 4'd5;
   localparam logic [3:0] S_DSTR  = 4'd6;
   localparam logic [3:0] S_SCALE = 4'd7;
   localparam logic [3:0] S_DIVS  = 4'd8;
   localparam logic [3:0] S_DIV   = 4'd9;
   localparam logic [3:0] S_VEL   = 4'd10;
   localparam logic [3:0] S_MIX   = 4'd11;
   localparam logic [3:0] S_MULT  = 4'd12;
   localparam logic [3:0] S_DONE  = 4'd13;

   localparam logic [deo_pkg::CNT_W-1:0] MUL_LAST =
      deo_pkg::CNT_W'(deo_pkg::MUL_STEPS - 1);
   localparam logic [deo_pkg::CNT_W-1:0] DIV_LAST =
      deo_pkg::CNT_W'(deo_pkg::DIV_N - 1);

   logic [3:0]                  state_ff, state_in;
   logic [deo_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // next state and command decode
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cmd.cal  = req_action;
               state_in = req_action ? S_DONE : S_ANG;
            end
         end
         S_ANG: begin
            cmd.ang  = 1'b1;
            state_in = S_MLS;
         end
         S_MLS: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = deo_pkg::MSEL_LEFT;
            cnt_in        = '0;
            state_in      = S_MULL;
         end
         S_MULL: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               cnt_in   = '0;
               state_in = S_DSTL;
            end
         end
         S_DSTL: begin
            cmd.dist_l    = 1'b1;
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = deo_pkg::MSEL_RIGHT;
            state_in      = S_MULR;
         end
         S_MULR: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               cnt_in   = '0;
               state_in = S_DSTR;
            end
         end
         S_DSTR: begin
            cmd.dist_r = 1'b1;
            state_in   = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_DIVS;
         end
         S_DIVS: begin
            cmd.div_start = 1'b1;
            cnt_in        = '0;
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = '0;
               state_in = S_VEL;
            end
         end
         S_VEL: begin
            cmd.vel  = 1'b1;
            state_in = S_MIX;
         end
         S_MIX: begin
            cmd.mix       = 1'b1;
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = deo_pkg::MSEL_DIFF;
            state_in      = S_MULT;
         end
         S_MULT: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               cnt_in   = '0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // load the output register once the previous response is gone
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/deo_datapath.sv =====
// odometry datapath: registers, turn counting, multiplier, dividers, outputs
module deo_datapath #(
   parameter int FRAME_BITS = 18,
   parameter int ANGLE_BITS = 12,
   parameter int TURN_BITS  = 20
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  deo_pkg::deo_cmd_type                   cmd,
   input  logic                                   csr_we,
   input  logic [deo_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [deo_pkg::REG_W-1:0]              csr_wdata,
   input  logic [FRAME_BITS-1:0]                  req_left_frame,
   input  logic [FRAME_BITS-1:0]                  req_right_frame,
   input  logic [deo_pkg::DT_W-1:0]               req_elapsed_us,
   output logic [ANGLE_BITS-1:0]                  rsp_left_position,
   output logic [ANGLE_BITS-1:0]                  rsp_right_position,
   output logic signed [deo_pkg::OUT_W-1:0]       rsp_left_distance,
   output logic signed [deo_pkg::OUT_W-1:0]       rsp_right_distance,
   output logic signed [deo_pkg::OUT_W-1:0]       rsp_forward_velocity,
   output logic signed [deo_pkg::OUT_W-1:0]       rsp_turn_rate
);

   localparam int AB     = ANGLE_BITS;
   localparam int TB     = TURN_BITS;
   localparam int CNT_WD = TB + AB;
   localparam int MA_W   = (CNT_WD > deo_pkg::SUM_W) ? CNT_WD : deo_pkg::SUM_W;
   localparam int PW     = MA_W + deo_pkg::REG_W;
   localparam int CW     = ((AB > deo_pkg::THR_W) ? AB : deo_pkg::THR_W) + 2;
   localparam int DW     = deo_pkg::DIST_W;
   localparam int NW     = deo_pkg::DIV_N;
   localparam int VW     = deo_pkg::VEL_W;
   localparam int SW     = deo_pkg::SUM_W;
   localparam int OW     = deo_pkg::OUT_W;
   localparam logic [PW-1:0] LIM_NEG = PW'(64'h8000_0000);
   localparam logic [PW-1:0] LIM_POS = PW'(64'h7FFF_FFFF);

   // saturate a magnitude with a sign into the distance range
   function automatic logic signed [DW-1:0] sat_mag(input logic neg,
                                                    input logic [PW-1:0] mag);
      logic [DW-1:0] m;
      if (neg) begin
         m = (mag > LIM_NEG) ? DW'(LIM_NEG) : DW'(mag);
         return -$signed(m);
      end
      m = (mag > LIM_POS) ? DW'(LIM_POS) : DW'(mag);
      return $signed(m);
   endfunction

   // turn count after a wrap test on the angle jump
   function automatic logic [TB-1:0] next_turns(input logic [AB-1:0] ang,
                                                input logic [AB-1:0] last,
                                                input logic [TB-1:0] t,
                                                input logic [deo_pkg::THR_W-1:0] thr);
      logic signed [CW-1:0] jump;
      logic signed [CW-1:0] thr_s;
      logic                 dec;
      logic                 inc;
      jump  = $signed(CW'(ang)) - $signed(CW'(last));
      thr_s = $signed(CW'(thr));
      dec   = (jump >= thr_s);
      inc   = (jump <= -thr_s);
      return t + TB'(inc) - TB'(dec);
   endfunction

   // configuration registers
   logic [deo_pkg::REG_W-1:0] dpc_ff, inv_ff;
   logic [deo_pkg::THR_W-1:0] thr_ff;

   // odometry state
   logic [AB-1:0]        rest_l_ff, rest_r_ff, last_l_ff, last_r_ff;
   logic [TB-1:0]        turns_l_ff, turns_r_ff;
   logic signed [DW-1:0] lastd_l_ff, lastd_r_ff;

   // per-request working registers
   logic [AB-1:0]        raw_l_ff, raw_r_ff, rel_l_ff, rel_r_ff;
   logic [deo_pkg::DT_W-1:0] dt_ff;
   logic                 cal_ff;
   logic signed [DW-1:0] ld_ff, rd_ff;
   logic [NW-1:0]        nl_ff, nr_ff;
   logic                 nl_neg_ff, nr_neg_ff;
   logic signed [VW-1:0] vl_ff, vr_ff;
   logic signed [OW-1:0] fwd_ff;
   logic                 dneg_ff;
   logic [PW-1:0]        ma_ff, acc_ff;
   logic [deo_pkg::REG_W-1:0] mb_ff;

   // combinational values
   logic [AB-1:0]        raw_l_c, raw_r_c, rel_l_c, rel_r_c;
   logic signed [CNT_WD-1:0] cnt_l, cnt_r;
   logic [CNT_WD-1:0]    mag_l, mag_r;
   logic signed [DW:0]   dl_c, dr_c;
   logic signed [SW-1:0] sl_c, sr_c;
   logic [SW-1:0]        sl_mag, sr_mag;
   logic [NW-1:0]        ql, qr;
   logic signed [SW-1:0] sum_c, diff_c;
   logic [SW-1:0]        sum_mag, diff_mag;
   logic signed [DW-1:0] fwd_c, turn_c;
   logic [MA_W-1:0]      mul_a;
   logic                 zero_dt;

   // angle extraction and relative angles
   always_comb begin
      raw_l_c = req_left_frame[FRAME_BITS-1 -: AB];
      raw_r_c = req_right_frame[FRAME_BITS-1 -: AB];
      rel_l_c = raw_l_ff - rest_l_ff;
      rel_r_c = raw_r_ff - rest_r_ff;
   end

   // signed counts and their magnitudes
   always_comb begin
      cnt_l = $signed({turns_l_ff, rel_l_ff});
      cnt_r = $signed({turns_r_ff, rel_r_ff});
      mag_l = cnt_l[CNT_WD-1] ? CNT_WD'(-cnt_l) : CNT_WD'(cnt_l);
      mag_r = cnt_r[CNT_WD-1] ? CNT_WD'(-cnt_r) : CNT_WD'(cnt_r);
   end

   // distance change scaled by one thousand
   always_comb begin
      dl_c   = (DW+1)'(ld_ff) - (DW+1)'(lastd_l_ff);
      dr_c   = (DW+1)'(rd_ff) - (DW+1)'(lastd_r_ff);
      sl_c   = SW'(dl_c) * SW'(deo_pkg::VEL_SCALE);
      sr_c   = SW'(dr_c) * SW'(deo_pkg::VEL_SCALE);
      sl_mag = sl_c[SW-1] ? SW'(-sl_c) : SW'(sl_c);
      sr_mag = sr_c[SW-1] ? SW'(-sr_c) : SW'(sr_c);
   end

   // forward mean and velocity difference
   always_comb begin
      sum_c    = SW'(vl_ff) + SW'(vr_ff);
      diff_c   = SW'(vr_ff) - SW'(vl_ff);
      sum_mag  = sum_c[SW-1] ? SW'(-sum_c) : SW'(sum_c);
      diff_mag = diff_c[SW-1] ? SW'(-diff_c) : SW'(diff_c);
      fwd_c    = sat_mag(sum_c[SW-1], PW'(sum_mag >> 1));
      turn_c   = sat_mag(dneg_ff, acc_ff >> deo_pkg::TURN_SHIFT);
      zero_dt  = (dt_ff == '0);
   end

   // multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         deo_pkg::MSEL_LEFT:  mul_a = MA_W'(mag_l);
         deo_pkg::MSEL_RIGHT: mul_a = MA_W'(mag_r);
         deo_pkg::MSEL_DIFF:  mul_a = MA_W'(diff_mag);
         default:             mul_a = '0;
      endcase
   end

   // configuration and odometry state
   always_ff @(posedge clock) begin
      if (reset) begin
         dpc_ff     <= deo_pkg::DPC_RESET;
         inv_ff     <= deo_pkg::INV_RESET;
         thr_ff     <= deo_pkg::THR_RESET;
         rest_l_ff  <= '0;
         rest_r_ff  <= '0;
         last_l_ff  <= '0;
         last_r_ff  <= '0;
         turns_l_ff <= '0;
         turns_r_ff <= '0;
         lastd_l_ff <= '0;
         lastd_r_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               deo_pkg::CSR_DIST_PER_COUNT:  dpc_ff <= csr_wdata;
               deo_pkg::CSR_INV_TRACK_WIDTH: inv_ff <= csr_wdata;
               deo_pkg::CSR_WRAP_THRESHOLD:  thr_ff <= csr_wdata[deo_pkg::THR_W-1:0];
               default: ;
            endcase
         end
         if (cmd.load && cmd.cal) begin
            rest_l_ff <= raw_l_c;
            rest_r_ff <= raw_r_c;
         end
         if (cmd.ang) begin
            turns_l_ff <= next_turns(rel_l_c, last_l_ff, turns_l_ff, thr_ff);
            turns_r_ff <= next_turns(rel_r_c, last_r_ff, turns_r_ff, thr_ff);
            last_l_ff  <= rel_l_c;
            last_r_ff  <= rel_r_c;
         end
         if (cmd.out_load && !cal_ff) begin
            lastd_l_ff <= ld_ff;
            lastd_r_ff <= rd_ff;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         raw_l_ff <= raw_l_c;
         raw_r_ff <= raw_r_c;
         dt_ff    <= req_elapsed_us;
         cal_ff   <= cmd.cal;
      end
      if (cmd.ang) begin
         rel_l_ff <= rel_l_c;
         rel_r_ff <= rel_r_c;
      end
      // shift-add multiplier, one byte of the register operand a step
      if (cmd.mul_start) begin
         ma_ff  <= PW'(mul_a);
         mb_ff  <= (cmd.mul_sel == deo_pkg::MSEL_DIFF) ? inv_ff : dpc_ff;
         acc_ff <= '0;
      end else if (cmd.mul_step) begin
         acc_ff <= acc_ff + ma_ff * PW'(mb_ff[deo_pkg::MUL_DIGIT-1:0]);
         ma_ff  <= ma_ff << deo_pkg::MUL_DIGIT;
         mb_ff  <= mb_ff >> deo_pkg::MUL_DIGIT;
      end
      if (cmd.dist_l) begin
         ld_ff <= -sat_mag(cnt_l[CNT_WD-1], acc_ff >> deo_pkg::DIST_SHIFT);
      end
      if (cmd.dist_r) begin
         rd_ff <= sat_mag(cnt_r[CNT_WD-1], acc_ff >> deo_pkg::DIST_SHIFT);
      end
      if (cmd.scale) begin
         nl_ff     <= sl_mag[NW-1:0];
         nr_ff     <= sr_mag[NW-1:0];
         nl_neg_ff <= sl_c[SW-1];
         nr_neg_ff <= sr_c[SW-1];
      end
      if (cmd.vel) begin
         vl_ff <= nl_neg_ff ? -$signed({1'b0, ql}) : $signed({1'b0, ql});
         vr_ff <= nr_neg_ff ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
      end
      if (cmd.mix) begin
         fwd_ff  <= fwd_c[OW-1:0];
         dneg_ff <= diff_c[SW-1];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (cal_ff) begin
            rsp_left_position    <= '0;
            rsp_right_position   <= '0;
            rsp_left_distance    <= lastd_l_ff[OW-1:0];
            rsp_right_distance   <= lastd_r_ff[OW-1:0];
            rsp_forward_velocity <= '0;
            rsp_turn_rate        <= '0;
         end else begin
            rsp_left_position    <= rel_l_ff;
            rsp_right_position   <= rel_r_ff;
            rsp_left_distance    <= ld_ff[OW-1:0];
            rsp_right_distance   <= rd_ff[OW-1:0];
            rsp_forward_velocity <= zero_dt ? '0 : fwd_ff;
            rsp_turn_rate        <= zero_dt ? '0 : turn_c[OW-1:0];
         end
      end
   end

   // wheel velocity dividers, both wheels at once
   deo_div #(.N(NW), .D(deo_pkg::DT_W)) u_div_l (
      .clock    (clock),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .dividend (nl_ff),
      .divisor  (dt_ff),
      .quotient (ql)
   );

   deo_div #(.N(NW), .D(deo_pkg::DT_W)) u_div_r (
      .clock    (clock),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .dividend (nr_ff),
      .divisor  (dt_ff),
      .quotient (qr)
   );

endmodule

// ===== src/dual_absolute_encoder_odometry_top.sv =====
// top level of the differential drive wheel odometry block
// Usage:
//  - req channel (valid/ready) carries one request: both 18-bit encoder frames,
//    the action bit (0 sample, 1 calibrate) and the elapsed microseconds.
//  - rsp channel (valid/ready) returns one result per request: relative
//    angles, wheel distances, forward velocity and turn rate.
//  - csr port writes dist_per_count (0), inv_track_width (1) and
//    wrap_threshold (2) with no wait state; write only while idle.
// Sequencing:
//  - a sample request runs the angle step, the byte-serial multiplier
//    (three passes of 4 steps) for both wheel distances and the turn rate,
//    and the 42-step radix-2 velocity dividers of both wheels
//  - a calibrate request skips all arithmetic and goes straight to the result
//  - one request is worked on at a time; the next can be taken in the cycle
//    after the result enters the output register
// Reset clears all turn counts, angles, distances and restores register
// defaults. When the receiver stalls, the finished result holds in the
// output register and a following result waits until it is taken.
module dual_absolute_encoder_odometry_top #(
   parameter int FRAME_BITS = 18,
   parameter int ANGLE_BITS = 12,
   parameter int TURN_BITS  = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_action,
   input  logic [FRAME_BITS-1:0]             req_left_frame,
   input  logic [FRAME_BITS-1:0]             req_right_frame,
   input  logic [deo_pkg::DT_W-1:0]          req_elapsed_us,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ANGLE_BITS-1:0]             rsp_left_position,
   output logic [ANGLE_BITS-1:0]             rsp_right_position,
   output logic signed [deo_pkg::OUT_W-1:0]  rsp_left_distance,
   output logic signed [deo_pkg::OUT_W-1:0]  rsp_right_distance,
   output logic signed [deo_pkg::OUT_W-1:0]  rsp_forward_velocity,
   output logic signed [deo_pkg::OUT_W-1:0]  rsp_turn_rate,
   input  logic                              csr_we,
   input  logic [deo_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [deo_pkg::REG_W-1:0]         csr_wdata
);

   deo_pkg::deo_cmd_type cmd;

   // sequencer
   deo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd)
   );

   // arithmetic and state
   deo_datapath #(
      .FRAME_BITS (FRAME_BITS),
      .ANGLE_BITS (ANGLE_BITS),
      .TURN_BITS  (TURN_BITS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_left_frame       (req_left_frame),
      .req_right_frame      (req_right_frame),
      .req_elapsed_us       (req_elapsed_us),
      .rsp_left_position    (rsp_left_position),
      .rsp_right_position   (rsp_right_position),
      .rsp_left_distance    (rsp_left_distance),
      .rsp_right_distance   (rsp_right_distance),
      .rsp_forward_velocity (rsp_forward_velocity),
      .rsp_turn_rate        (rsp_turn_rate)
   );

endmodule

// ===== src/deo_checker.sv =====
// port-level assertion checker of the wheel odometry block, with its bind
`include "dual_absolute_encoder_odometry_top_macros.svh"

module deo_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // idle with no response right after reset
   `DEO_ASSERT_ALL(a_reset_idle, clock, reset |=> (req_ready && !rsp_valid), "not idle after reset")

   // one request in flight at a time
   `DEO_ASSERT_RUN(a_one_req, clock, reset, (req_valid && req_ready) |=> !req_ready, "request taken while busy")

   // a new response only appears while requests are held off
   `DEO_ASSERT_RUN(a_rsp_rise, clock, reset, $rose(rsp_valid) |-> $past(!req_ready), "response rose while idle")

   // a stalled response stays
   `DEO_ASSERT_RUN(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid, "response dropped")

endmodule

bind dual_absolute_encoder_odometry_top deo_checker u_deo_checker (.*);
